>>> sv/dwls_pkg.sv
package dwls_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int FRAC_BITS_DEF = 8;

    localparam int COLUMN_W = 10;
    localparam int PIXEL_W  = 16;
    localparam int DISP_W   = 21;
    localparam int SAMPLE_W = 24;
    localparam int WIDTH_W  = 11;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1024);

    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;

    typedef enum logic {
        ACTION_LOAD   = 1'b0,
        ACTION_SAMPLE = 1'b1
    } action_t;

endpackage

>>> sv/dwls_ram.sv
module dwls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/disparity_warp_line_sampler_core.sv
// Disparity warp line sampler.
//
// Input stream (s_*): one request per cycle. s_tuser[0] selects the action:
// a load writes the pixel in s_tdata into the line buffer at its column, a
// sample reads the two neighbouring pixels around column + disparity and
// blends them with the disparity fraction. Loads give no result; every sample
// gives one result on m_* with FRAC_BITS fraction bits, saturated to 24 bits.
// Taps outside 0 .. min(width, MAX_WIDTH)-1 count as zero.
// Configuration: cfg_data sets the row width in use; it is always accepted
// and must only be written while the block is idle.
// Pipeline: a sample passes the buffer read, the two weight multipliers, and
// the add and saturate into the output register.
// Throughput: one request per cycle, set by the two read ports of the line
// buffer, kept as two copies written together; a load may be followed at once
// by a sample of the same column.
// Reset clears the pipeline and sets the width to 1024; the line buffer keeps
// whatever it held and must be loaded before it is sampled.
// When m_tready is low the result holds in the output register and the stages
// behind it keep filling; s_tready drops only once every stage holds a sample.
module disparity_warp_line_sampler_core #(
    parameter int MAX_WIDTH = dwls_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = dwls_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: column[9:0], pixel_value[25:10], disparity[46:26], zero[47]
    input  logic [dwls_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: action[0]
    input  logic [0:0]                     s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: sample_value[23:0]
    output logic [dwls_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dwls_pkg::WIDTH_W-1:0]   cfg_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready
);

    import dwls_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int POS_W  = DISP_W + 2;
    localparam int WGT_W  = FRAC_BITS + 2;
    localparam int PROD_W = PIXEL_W + WGT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int EXT_W  = (SUM_W > SAMPLE_W) ? SUM_W : SAMPLE_W;

    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(SAMPLE_MAX);
    localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(SAMPLE_MIN);
    localparam logic [FRAC_BITS:0]      ONE_W   = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    // input fields
    logic [COLUMN_W-1:0]      col_in;
    logic signed [PIXEL_W-1:0] pix_in;
    logic signed [DISP_W-1:0] disp_in;
    action_t                  action_in;

    assign col_in    = s_tdata[COLUMN_W-1:0];
    assign pix_in    = s_tdata[COLUMN_W+PIXEL_W-1:COLUMN_W];
    assign disp_in   = s_tdata[COLUMN_W+PIXEL_W+DISP_W-1:COLUMN_W+PIXEL_W];
    assign action_in = action_t'(s_tuser[0]);

    // stage enables, back to front
    logic en_out;
    logic en2;
    logic en1;
    logic s_acc;

    logic width_zero;
    logic [WIDTH_W-1:0] width_cfg_reg;

    logic v1_reg, v1_next;
    logic v2_reg;

    assign en_out   = !m_tvalid || m_tready;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg <= WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            width_cfg_reg <= cfg_data;
        end
    end

    // a width of zero leaves no tap in range
    assign width_zero = (width_cfg_reg == '0);

    // position: n = column + floor(disparity), f = low fraction bits
    logic signed [POS_W-1:0] pos0;
    logic signed [POS_W-1:0] pos1;
    logic signed [POS_W-1:0] w_eff;
    logic                    ok0_next, ok1_next;
    logic [AW-1:0]           rd_addr0, rd_addr1;
    logic                    wr_en;

    assign pos0  = POS_W'($signed({1'b0, col_in})) + POS_W'(disp_in >>> FRAC_BITS);
    assign pos1  = pos0 + POS_W'(1);
    assign w_eff = (32'(width_cfg_reg) < MAX_WIDTH) ? POS_W'(width_cfg_reg)
                                                    : POS_W'(MAX_WIDTH);

    assign ok0_next = !width_zero && (pos0 >= 0) && (pos0 < w_eff);
    assign ok1_next = !width_zero && (pos1 >= 0) && (pos1 < w_eff);
    assign rd_addr0 = AW'(pos0);
    assign rd_addr1 = AW'(pos1);

    assign wr_en   = s_acc && (action_in == ACTION_LOAD) && (32'(col_in) < MAX_WIDTH);
    assign v1_next = s_acc && (action_in == ACTION_SAMPLE);

    logic [PIXEL_W-1:0] q0, q1;

    dwls_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_tap0 (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(col_in)),
        .wr_data (pix_in),
        .rd_en   (en1),
        .rd_addr (rd_addr0),
        .rd_data (q0)
    );

    dwls_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_tap1 (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(col_in)),
        .wr_data (pix_in),
        .rd_en   (en1),
        .rd_addr (rd_addr1),
        .rd_data (q1)
    );

    // stage 1: buffer read
    logic [FRAC_BITS-1:0] frac1_reg;
    logic                 ok0_reg, ok1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            frac1_reg <= disp_in[FRAC_BITS-1:0];
            ok0_reg   <= ok0_next;
            ok1_reg   <= ok1_next;
        end
    end

    // stage 2: weight each tap
    logic signed [PIXEL_W-1:0] tap0, tap1;
    logic [FRAC_BITS:0]        wgt0;
    logic signed [WGT_W-1:0]   wgt0_s, wgt1_s;
    logic signed [PROD_W-1:0]  prod0_next, prod1_next;
    logic signed [PROD_W-1:0]  prod0_reg, prod1_reg;

    assign tap0   = ok0_reg ? $signed(q0) : '0;
    assign tap1   = ok1_reg ? $signed(q1) : '0;
    assign wgt0   = ONE_W - {1'b0, frac1_reg};
    assign wgt0_s = $signed({1'b0, wgt0});
    assign wgt1_s = $signed({2'b00, frac1_reg});

    assign prod0_next = wgt0_s * tap0;
    assign prod1_next = wgt1_s * tap1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            prod0_reg <= prod0_next;
            prod1_reg <= prod1_next;
        end
    end

    // stage 3: add and saturate into the output register
    logic signed [SUM_W-1:0]    sum;
    logic signed [EXT_W-1:0]    sum_ext;
    logic [SAMPLE_W-1:0]        sample_next;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic                       m_valid_reg;

    assign sum     = SUM_W'(prod0_reg) + SUM_W'(prod1_reg);
    assign sum_ext = EXT_W'(sum);

    always_comb begin
        if (sum_ext > SAT_MAX) begin
            sample_next = SAMPLE_W'(SAT_MAX);
        end else if (sum_ext < SAT_MIN) begin
            sample_next = SAMPLE_W'(SAT_MIN);
        end else begin
            sample_next = SAMPLE_W'(sum_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && v2_reg) begin
            sample_reg <= sample_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sample_reg;

    // the input stalls only behind a held result
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output free");

    a_stage2_from_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v2_reg) |-> $past(v1_reg))
        else $error("stage 2 filled without a sample in stage 1");

    a_result_from_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v2_reg))
        else $error("result raised without a weighted sample");

    a_load_no_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && action_in == ACTION_LOAD) |=> !v1_reg)
        else $error("load request entered the sample pipeline");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dwls_pkg::*;

    localparam int    ROW_MAX     = MAX_WIDTH_DEF;
    localparam int    FRAC        = FRAC_BITS_DEF;
    localparam longint ONE        = longint'(1) << FRAC;
    localparam longint POS_BIAS   = longint'(1) << 30;
    localparam int    CYCLE_LIMIT = 400000;
    localparam int    PHASE_ITEMS = 185;

    typedef struct {
        action_t                   action;
        logic [COLUMN_W-1:0]       column;
        logic signed [PIXEL_W-1:0] pixel_value;
        logic signed [DISP_W-1:0]  disparity;
    } warp_request_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [WIDTH_W-1:0]     cfg_data = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;

    // predictor state
    logic signed [PIXEL_W-1:0]  row_store [ROW_MAX];
    logic [WIDTH_W-1:0]         row_width = WIDTH_RESET;
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    // stimulus state
    warp_request_t pending_requests [$];
    warp_request_t offered;
    bit            loaded [ROW_MAX];
    int            plan_width = 1024;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_off_left = 0;
    int            error_count = 0;
    int            cycle_count = 0;
    int            queued_total = 0;
    bit            cfg_busy = 1'b0;
    logic [WIDTH_W-1:0] cfg_value = '0;

    disparity_warp_line_sampler_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [SAMPLE_W-1:0] warped_sample(
        logic [COLUMN_W-1:0] col, logic signed [DISP_W-1:0] disp);
        longint pos, n, f, w, left, right, acc;
        pos = longint'(col) * ONE + longint'(disp) + POS_BIAS;
        n = (pos >>> FRAC) - (POS_BIAS >>> FRAC);
        f = pos & (ONE - 1);
        w = (row_width < ROW_MAX) ? longint'(row_width) : ROW_MAX;
        left = 0;
        right = 0;
        if (n >= 0 && n < w) left = row_store[n];
        if (n + 1 >= 0 && n + 1 < w) right = row_store[n + 1];
        acc = (ONE - f) * left + f * right;
        if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
        if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
        return acc[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic queue_load(logic [COLUMN_W-1:0] col, logic signed [PIXEL_W-1:0] value);
        warp_request_t r;
        r.action = ACTION_LOAD;
        r.column = col;
        r.pixel_value = value;
        r.disparity = DISP_W'($urandom);
        loaded[col] = 1'b1;
        pending_requests.push_back(r);
        queued_total++;
    endtask

    // Load any tap inside the row that has never been written, so no sample
    // ever reads an undefined buffer entry.
    task automatic queue_sample(logic [COLUMN_W-1:0] col, logic signed [DISP_W-1:0] disp);
        warp_request_t r;
        longint n;
        int w;
        n = ((longint'(col) * ONE + longint'(disp) + POS_BIAS) >>> FRAC)
            - (POS_BIAS >>> FRAC);
        w = (plan_width < ROW_MAX) ? plan_width : ROW_MAX;
        for (longint k = n; k <= n + 1; k++) begin
            if (k >= 0 && k < w && !loaded[k])
                queue_load(COLUMN_W'(k), PIXEL_W'($urandom));
        end
        r.action = ACTION_SAMPLE;
        r.column = col;
        r.pixel_value = PIXEL_W'($urandom);
        r.disparity = disp;
        pending_requests.push_back(r);
        queued_total++;
    endtask

    // Mostly aim the taps at or just around the row; otherwise any disparity.
    task automatic random_sample();
        int w, n, col;
        w = (plan_width < ROW_MAX) ? plan_width : ROW_MAX;
        col = $urandom_range(ROW_MAX - 1);
        if ($urandom_range(99) < 80) begin
            n = int'($urandom_range(w + 3)) - 2;
            queue_sample(COLUMN_W'(col),
                         DISP_W'((n - col) * ONE + int'($urandom_range(ONE - 1))));
        end else begin
            queue_sample(COLUMN_W'(col), DISP_W'($urandom));
        end
    endtask

    task automatic random_request();
        if ($urandom_range(99) < 35)
            queue_load(COLUMN_W'($urandom_range(ROW_MAX - 1)), PIXEL_W'($urandom));
        else
            random_sample();
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_samples.size() != 0);
        // loads give no result, so let the pipeline drain
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_width(int value);
        cfg_value = WIDTH_W'(value);
        plan_width = value;
        cfg_busy = 1'b1;
        do @(posedge aclk);
        while (cfg_busy);
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cfg_valid && cfg_ready) begin
            row_width = cfg_data;
            cfg_valid <= 1'b0;
            cfg_busy = 1'b0;
        end else if (cfg_busy) begin
            cfg_valid <= 1'b1;
            cfg_data <= cfg_value;
        end
    end

    // request driver; predict each request as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (offered.action == ACTION_LOAD)
                    row_store[offered.column] = offered.pixel_value;
                else
                    expected_samples.push_back(warped_sample(offered.column,
                                                             offered.disparity));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0
                        && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= offered.action;
                    s_tdata <= {1'b0, offered.disparity, offered.pixel_value,
                                offered.column};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("sample %0d with no request pending",
                                          $signed(m_tdata)));
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata !== want)
                    report_mismatch($sformatf("sample_value got %0d expected %0d",
                                              $signed(m_tdata), want));
            end
        end
    end

    initial begin
        int widths [8];
        int send_modes [4];
        int recv_modes [4];
        int phase_start;
        widths = '{1024, 1, 2047, 0, 37, 1000, 2, 513};
        send_modes = '{0, 64, 0, 25};
        recv_modes = '{0, 0, 64, 25};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_width(1024);
        queue_load(0, 16'sh7FFF);
        queue_load(1, 16'sh8000);
        queue_load(1023, 16'sh8000);
        queue_load(1022, 16'sh7FFF);
        queue_sample(0, 0);
        queue_sample(1, 0);
        queue_sample(0, 128);
        queue_sample(0, 255);
        queue_sample(0, -1);
        queue_sample(0, -256);
        queue_sample(1023, 0);
        queue_sample(1022, 255);
        queue_sample(1023, -256);
        queue_sample(512, 21'sh0FFFFF);
        queue_sample(512, 21'sh100000);
        // sample straight after a load of the same column
        queue_load(700, PIXEL_W'($urandom));
        queue_sample(700, 0);
        queue_load(5, PIXEL_W'($urandom));
        queue_sample(4, 128);
        wait_idle();

        // hold the result side while requests keep coming, to fill the pipeline
        hold_off_left = 250;
        repeat (60) random_sample();
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            write_width(widths[p]);
            send_idle_pct = send_modes[p % 4];
            recv_stall_pct = recv_modes[p % 4];
            // count the tap loads added for unwritten entries against the phase
            phase_start = queued_total;
            while (queued_total - phase_start < PHASE_ITEMS)
                random_request();
            wait_idle();
        end

        repeat (16) @(posedge aclk);
        if (error_count == 0 && expected_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
sv/dwls_pkg.sv
sv/dwls_ram.sv
sv/disparity_warp_line_sampler_core.sv
bench/testbench.sv
